FILE: rtl/tsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared types, constants and pattern classifiers for the three-snapshot
// change classifier.
// ----------------------------------------------------------------------------
package tsc_pkg;

  // field widths
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned OFFSET_W    = 26;
  localparam int unsigned WINDOW_W    = 24;
  localparam int unsigned CHG_ROWS_W  = 19;
  localparam int unsigned CAND_ROWS_W = 17;
  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 32;

  // offset saturates here
  localparam logic [OFFSET_W-1:0] OFFSET_MAX = '1;

  // register reset values
  localparam logic [CHG_ROWS_W-1:0]  CHANGE_LIMIT_RST = 19'd300000;
  localparam logic [CAND_ROWS_W-1:0] CAND_LIMIT_RST   = 17'd100000;
  localparam logic [WORD_W-1:0]      RISE_LIMIT_RST   = 32'd1000;

  // pattern codes
  typedef enum logic [1:0] {
    PAT_NONE   = 2'd0,
    PAT_ZOZ    = 2'd1,
    PAT_STEP   = 2'd2,
    PAT_UPDOWN = 2'd3
  } pat_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHANGE_LIMIT = 2'd0,
    CFG_CAND_LIMIT   = 2'd1,
    CFG_RISE_LIMIT   = 2'd2
  } cfg_idx_e;

  // one input item
  typedef struct packed {
    logic [BYTE_W-1:0] first_value;
    logic [BYTE_W-1:0] second_value;
    logic [BYTE_W-1:0] third_value;
    logic              region_first;
    logic              comparison_first;
  } item_t;

  // change and candidate bookkeeping for one item
  typedef struct packed {
    logic               changed_ab;
    logic               changed_bc;
    logic               change_rep;
    logic               byte_rep;
    logic               word_rep;
    logic [COUNT_W-1:0] count_ab;
    logic [COUNT_W-1:0] count_bc;
  } count_res_t;

  // one result item
  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic                changed_ab;
    logic                changed_bc;
    logic                change_rep;
    pat_e                byte_pat;
    logic                byte_rep;
    pat_e                word_pat;
    logic                word_rep;
    logic [COUNT_W-1:0]  count_ab;
    logic [COUNT_W-1:0]  count_bc;
  } result_t;

  // byte triple classifier, increment wraps at 8 bits
  function automatic pat_e classify_byte(input logic [BYTE_W-1:0] a,
                                         input logic [BYTE_W-1:0] b,
                                         input logic [BYTE_W-1:0] c);
    pat_e pat;
    if (a == '0 && b == 8'd1 && c == '0) begin
      pat = PAT_ZOZ;
    end else if (b == a + 8'd1 && c == a) begin
      pat = PAT_STEP;
    end else if (b > a && c < b) begin
      pat = PAT_UPDOWN;
    end else begin
      pat = PAT_NONE;
    end
    return pat;
  endfunction

  // word triple classifier, rise of an up-down word is bounded
  function automatic pat_e classify_word(input logic [WORD_W-1:0] a,
                                         input logic [WORD_W-1:0] b,
                                         input logic [WORD_W-1:0] c,
                                         input logic [WORD_W-1:0] rise_limit);
    pat_e              pat;
    logic [WORD_W-1:0] rise;
    rise = b - a;
    if (a == '0 && b == 32'd1 && c == '0) begin
      pat = PAT_ZOZ;
    end else if (b == a + 32'd1 && c == a) begin
      pat = PAT_STEP;
    end else if (b > a && c < b && rise <= rise_limit) begin
      pat = PAT_UPDOWN;
    end else begin
      pat = PAT_NONE;
    end
    return pat;
  endfunction

endpackage

FILE: rtl/tsc_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_window
// Region offset counter and the three byte windows; classifies the
// little-endian word that ends at the current byte.
// ----------------------------------------------------------------------------
module tsc_window import tsc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                exec_i,
  input  item_t               item_i,
  input  logic [WORD_W-1:0]   rise_limit_i,
  output logic [OFFSET_W-1:0] offset_o,
  output pat_e                word_pat_o
);

  logic [OFFSET_W-1:0] pos_q, pos_d;
  logic [WINDOW_W-1:0] win_a_q, win_a_d;
  logic [WINDOW_W-1:0] win_b_q, win_b_d;
  logic [WINDOW_W-1:0] win_c_q, win_c_d;
  logic [WINDOW_W-1:0] win_a, win_b, win_c;
  logic                full;

  // a region start empties the window and restarts the offset
  always_comb begin
    offset_o = item_i.region_first ? '0 : pos_q;
    win_a    = item_i.region_first ? '0 : win_a_q;
    win_b    = item_i.region_first ? '0 : win_b_q;
    win_c    = item_i.region_first ? '0 : win_c_q;
    full     = (offset_o >= OFFSET_W'(3));
  end

  // word made of the three stored bytes and the current one
  always_comb begin
    if (full) begin
      word_pat_o = classify_word({item_i.first_value, win_a},
                                 {item_i.second_value, win_b},
                                 {item_i.third_value, win_c},
                                 rise_limit_i);
    end else begin
      word_pat_o = PAT_NONE;
    end
  end

  // next offset and shifted windows, oldest byte in the low byte
  always_comb begin
    pos_d   = (offset_o == OFFSET_MAX) ? offset_o : offset_o + OFFSET_W'(1);
    win_a_d = {item_i.first_value, win_a[WINDOW_W-1:BYTE_W]};
    win_b_d = {item_i.second_value, win_b[WINDOW_W-1:BYTE_W]};
    win_c_d = {item_i.third_value, win_c[WINDOW_W-1:BYTE_W]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      win_a_q <= '0;
      win_b_q <= '0;
      win_c_q <= '0;
    end else if (exec_i) begin
      pos_q   <= pos_d;
      win_a_q <= win_a_d;
      win_b_q <= win_b_d;
      win_c_q <= win_c_d;
    end
  end

endmodule

FILE: rtl/tsc_count.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_count
// Saturating change counts and the change and candidate row counters with
// their limits.
// ----------------------------------------------------------------------------
module tsc_count import tsc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   exec_i,
  input  item_t                  item_i,
  input  pat_e                   byte_pat_i,
  input  pat_e                   word_pat_i,
  input  logic [CHG_ROWS_W-1:0]  change_limit_i,
  input  logic [CAND_ROWS_W-1:0] cand_limit_i,
  output count_res_t             res_o
);

  logic [COUNT_W-1:0]     cnt_ab_q, cnt_ab_d, cnt_ab;
  logic [COUNT_W-1:0]     cnt_bc_q, cnt_bc_d, cnt_bc;
  logic [CHG_ROWS_W-1:0]  chg_rows_q, chg_rows_d, chg_rows;
  logic [CAND_ROWS_W-1:0] cand_rows_q, cand_rows_d, cand_rows, cand_mid;
  logic                   d_ab, d_bc, chg_rep, byte_rep, word_rep;

  // a new comparison starts all counters from zero
  always_comb begin
    cnt_ab    = item_i.comparison_first ? '0 : cnt_ab_q;
    cnt_bc    = item_i.comparison_first ? '0 : cnt_bc_q;
    chg_rows  = item_i.comparison_first ? '0 : chg_rows_q;
    cand_rows = item_i.comparison_first ? '0 : cand_rows_q;
  end

  // change flags and saturating counts
  always_comb begin
    d_ab     = (item_i.first_value != item_i.second_value);
    d_bc     = (item_i.second_value != item_i.third_value);
    cnt_ab_d = (d_ab && cnt_ab != '1) ? cnt_ab + COUNT_W'(1) : cnt_ab;
    cnt_bc_d = (d_bc && cnt_bc != '1) ? cnt_bc + COUNT_W'(1) : cnt_bc;
  end

  // change rows stop at their limit
  always_comb begin
    chg_rep    = (d_ab || d_bc) && (chg_rows < change_limit_i);
    chg_rows_d = chg_rows + CHG_ROWS_W'(chg_rep);
  end

  // candidate rows, byte row taken before the word row
  always_comb begin
    byte_rep    = (byte_pat_i != PAT_NONE) && (cand_rows < cand_limit_i);
    cand_mid    = cand_rows + CAND_ROWS_W'(byte_rep);
    word_rep    = (word_pat_i != PAT_NONE) && (cand_mid < cand_limit_i);
    cand_rows_d = cand_mid + CAND_ROWS_W'(word_rep);
  end

  always_comb begin
    res_o.changed_ab = d_ab;
    res_o.changed_bc = d_bc;
    res_o.change_rep = chg_rep;
    res_o.byte_rep   = byte_rep;
    res_o.word_rep   = word_rep;
    res_o.count_ab   = cnt_ab_d;
    res_o.count_bc   = cnt_bc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_ab_q    <= '0;
      cnt_bc_q    <= '0;
      chg_rows_q  <= '0;
      cand_rows_q <= '0;
    end else if (exec_i) begin
      cnt_ab_q    <= cnt_ab_d;
      cnt_bc_q    <= cnt_bc_d;
      chg_rows_q  <= chg_rows_d;
      cand_rows_q <= cand_rows_d;
    end
  end

endmodule

FILE: rtl/three_snapshot_change_classifier_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_snapshot_change_classifier_core
// Classifies one position of three memory snapshots per transaction: change
// flags and counts, byte pattern and the pattern of the word ending there.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+-----------------------------------------
//  cfg     | cfg_wr_en_i            | cfg_index_i, cfg_wdata_i
//  in      | in_valid_i, in_stall_o | snapshot bytes, region/comparison starts
//  out     | out_valid_o, out_stall_i | offset, flags, patterns, counts
//
//  one transaction per cycle sustained while out_stall_i is low; a result
//  passes the input register, then evaluation into the result register
//  the evaluation stage holds all running state and updates it when its
//  item moves into the result register
//  reset clears valids, counters, windows and loads the register defaults
//  a stalled result holds; the input register still takes one more item
// ----------------------------------------------------------------------------
module three_snapshot_change_classifier_core import tsc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_wr_en_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [BYTE_W-1:0]     first_value_i,
  input  logic [BYTE_W-1:0]     second_value_i,
  input  logic [BYTE_W-1:0]     third_value_i,
  input  logic                  region_first_i,
  input  logic                  comparison_first_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [OFFSET_W-1:0]   offset_o,
  output logic                  changed_first_second_o,
  output logic                  changed_second_third_o,
  output logic                  change_reported_o,
  output logic [1:0]            byte_pattern_o,
  output logic                  byte_candidate_reported_o,
  output logic [1:0]            word_pattern_o,
  output logic                  word_candidate_reported_o,
  output logic [COUNT_W-1:0]    count_first_second_o,
  output logic [COUNT_W-1:0]    count_second_third_o
);

  logic [CHG_ROWS_W-1:0]  change_limit_q;
  logic [CAND_ROWS_W-1:0] cand_limit_q;
  logic [WORD_W-1:0]      rise_limit_q;

  logic       in_valid_q, in_valid_d;
  item_t      item_q;
  logic       out_valid_q, out_valid_d;
  result_t    res_q, res_d;
  logic       advance, in_fire, exec;
  logic [OFFSET_W-1:0] offset;
  pat_e       byte_pat, word_pat;
  count_res_t cnt_res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      change_limit_q <= CHANGE_LIMIT_RST;
      cand_limit_q   <= CAND_LIMIT_RST;
      rise_limit_q   <= RISE_LIMIT_RST;
    end else if (cfg_wr_en_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_CHANGE_LIMIT: change_limit_q <= cfg_wdata_i[CHG_ROWS_W-1:0];
        CFG_CAND_LIMIT:   cand_limit_q   <= cfg_wdata_i[CAND_ROWS_W-1:0];
        CFG_RISE_LIMIT:   rise_limit_q   <= cfg_wdata_i[WORD_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake control
  always_comb begin
    advance     = !out_valid_q || !out_stall_i;
    in_stall_o  = in_valid_q && !advance;
    in_fire     = in_valid_i && !in_stall_o;
    exec        = in_valid_q && advance;
    in_valid_d  = in_fire ? 1'b1 : (exec ? 1'b0 : in_valid_q);
    out_valid_d = exec ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.first_value      <= first_value_i;
      item_q.second_value     <= second_value_i;
      item_q.third_value      <= third_value_i;
      item_q.region_first     <= region_first_i;
      item_q.comparison_first <= comparison_first_i;
    end
  end

  // evaluation
  assign byte_pat = classify_byte(item_q.first_value, item_q.second_value,
                                  item_q.third_value);

  tsc_window u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .exec_i       (exec),
    .item_i       (item_q),
    .rise_limit_i (rise_limit_q),
    .offset_o     (offset),
    .word_pat_o   (word_pat)
  );

  tsc_count u_count (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .exec_i         (exec),
    .item_i         (item_q),
    .byte_pat_i     (byte_pat),
    .word_pat_i     (word_pat),
    .change_limit_i (change_limit_q),
    .cand_limit_i   (cand_limit_q),
    .res_o          (cnt_res)
  );

  // result register
  always_comb begin
    res_d.offset     = offset;
    res_d.changed_ab = cnt_res.changed_ab;
    res_d.changed_bc = cnt_res.changed_bc;
    res_d.change_rep = cnt_res.change_rep;
    res_d.byte_pat   = byte_pat;
    res_d.byte_rep   = cnt_res.byte_rep;
    res_d.word_pat   = word_pat;
    res_d.word_rep   = cnt_res.word_rep;
    res_d.count_ab   = cnt_res.count_ab;
    res_d.count_bc   = cnt_res.count_bc;
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      res_q <= res_d;
    end
  end

  // output ports
  assign out_valid_o               = out_valid_q;
  assign offset_o                  = res_q.offset;
  assign changed_first_second_o    = res_q.changed_ab;
  assign changed_second_third_o    = res_q.changed_bc;
  assign change_reported_o         = res_q.change_rep;
  assign byte_pattern_o            = res_q.byte_pat;
  assign byte_candidate_reported_o = res_q.byte_rep;
  assign word_pattern_o            = res_q.word_pat;
  assign word_candidate_reported_o = res_q.word_rep;
  assign count_first_second_o      = res_q.count_ab;
  assign count_second_third_o      = res_q.count_bc;

endmodule

FILE: rtl/tsc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_checker
// Port-level checks of the change classifier core, bound to the top level.
// ----------------------------------------------------------------------------
module tsc_checker import tsc_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [OFFSET_W-1:0]   offset_o,
  input logic [1:0]            word_pattern_o,
  input logic                  word_candidate_reported_o,
  input logic [COUNT_W-1:0]    count_first_second_o,
  input logic [COUNT_W-1:0]    count_second_third_o
);

  // no result is shown while in reset
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

  // an empty result register never back-pressures the input
  a_empty_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty result register");

  // a transaction taken under a stalled output fills the only free slot
  a_one_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i && in_valid_i && !in_stall_o) ##1 out_stall_i
    |-> in_stall_o)
    else $error("input taken beyond buffer depth");

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
    out_valid_o && $stable(offset_o) && $stable(count_first_second_o) &&
    $stable(count_second_third_o) && $stable(word_pattern_o))
    else $error("stalled result changed");

  // no word is classified before three bytes of the region are seen
  a_short_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && offset_o < OFFSET_W'(3) |->
    word_pattern_o == PAT_NONE && !word_candidate_reported_o)
    else $error("word pattern on a short window");

endmodule

bind three_snapshot_change_classifier_core tsc_checker u_tsc_checker (.*);

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the three-snapshot change classifier core. Each
// accepted transaction is run through a local model of the change counts,
// row limits and byte/word pattern classes. The model result is queued and
// compared field by field with every result the core hands out. Directed
// corner cases come first, then randomized traffic under several register
// settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import tsc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_wr_en_i;
  cfg_idx_e              cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [BYTE_W-1:0]     first_value_i;
  logic [BYTE_W-1:0]     second_value_i;
  logic [BYTE_W-1:0]     third_value_i;
  logic                  region_first_i;
  logic                  comparison_first_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [OFFSET_W-1:0]   offset_o;
  logic                  changed_first_second_o;
  logic                  changed_second_third_o;
  logic                  change_reported_o;
  logic [1:0]            byte_pattern_o;
  logic                  byte_candidate_reported_o;
  logic [1:0]            word_pattern_o;
  logic                  word_candidate_reported_o;
  logic [COUNT_W-1:0]    count_first_second_o;
  logic [COUNT_W-1:0]    count_second_third_o;

  three_snapshot_change_classifier_core dut (
    .clk_i                     (clk_i),
    .rst_ni                    (rst_ni),
    .cfg_wr_en_i               (cfg_wr_en_i),
    .cfg_index_i               (cfg_index_i),
    .cfg_wdata_i               (cfg_wdata_i),
    .in_valid_i                (in_valid_i),
    .in_stall_o                (in_stall_o),
    .first_value_i             (first_value_i),
    .second_value_i            (second_value_i),
    .third_value_i             (third_value_i),
    .region_first_i            (region_first_i),
    .comparison_first_i        (comparison_first_i),
    .out_valid_o               (out_valid_o),
    .out_stall_i               (out_stall_i),
    .offset_o                  (offset_o),
    .changed_first_second_o    (changed_first_second_o),
    .changed_second_third_o    (changed_second_third_o),
    .change_reported_o         (change_reported_o),
    .byte_pattern_o            (byte_pattern_o),
    .byte_candidate_reported_o (byte_candidate_reported_o),
    .word_pattern_o            (word_pattern_o),
    .word_candidate_reported_o (word_candidate_reported_o),
    .count_first_second_o      (count_first_second_o),
    .count_second_third_o      (count_second_third_o)
  );

  // model copy of registers and running state
  logic [CHG_ROWS_W-1:0]  lim_chg;
  logic [CAND_ROWS_W-1:0] lim_cand;
  logic [WORD_W-1:0]      lim_rise;
  logic [OFFSET_W-1:0]    pos_cnt;
  logic [WINDOW_W-1:0]    win_a, win_b, win_c;
  logic [CHG_ROWS_W-1:0]  chg_rows;
  logic [CAND_ROWS_W-1:0] cand_rows;
  logic [COUNT_W-1:0]     cnt_ab, cnt_bc;

  result_t     classified_q[$];
  int unsigned mismatch_cnt;
  int unsigned cycle_cnt;
  bit          calm;
  int          stall_left;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // pattern class of a triple; bytes wrap their increment at 8 bits,
  // words wrap at 32 bits and bound the rise of an up-down shape
  function automatic pat_e triple_kind(input logic [31:0] a, input logic [31:0] b,
                                       input logic [31:0] c, input bit is_word);
    logic [31:0] succ;
    bit          rise_ok;
    succ = a + 32'd1;
    if (!is_word) succ[31:8] = '0;
    rise_ok = !is_word || ((b - a) <= lim_rise);
    if (a == 32'd0 && b == 32'd1 && c == 32'd0) return PAT_ZOZ;
    if (b == succ && c == a) return PAT_STEP;
    if (b > a && c < b && rise_ok) return PAT_UPDOWN;
    return PAT_NONE;
  endfunction

  // candidate row bookkeeping shared by byte and word rows
  function automatic logic claim_candidate(input pat_e kind);
    if (kind != PAT_NONE && cand_rows < lim_cand) begin
      cand_rows++;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // model of one position: advances the state and returns its result row
  function automatic result_t classify_position(input item_t it);
    result_t             r;
    logic [OFFSET_W-1:0] off;
    if (it.comparison_first) begin
      cnt_ab    = '0;
      cnt_bc    = '0;
      chg_rows  = '0;
      cand_rows = '0;
    end
    if (it.region_first) begin
      pos_cnt = '0;
      win_a   = '0;
      win_b   = '0;
      win_c   = '0;
    end
    off = pos_cnt;
    r = '0;
    r.offset     = off;
    r.changed_ab = it.first_value != it.second_value;
    r.changed_bc = it.second_value != it.third_value;
    if (r.changed_ab && cnt_ab != '1) cnt_ab++;
    if (r.changed_bc && cnt_bc != '1) cnt_bc++;
    if ((r.changed_ab || r.changed_bc) && chg_rows < lim_chg) begin
      chg_rows++;
      r.change_rep = 1'b1;
    end
    r.byte_pat = triple_kind({24'h0, it.first_value}, {24'h0, it.second_value},
                             {24'h0, it.third_value}, 1'b0);
    r.byte_rep = claim_candidate(r.byte_pat);
    // word is only complete from the fourth byte of a region on
    r.word_pat = PAT_NONE;
    if (off >= 3) begin
      r.word_pat = triple_kind({it.first_value, win_a}, {it.second_value, win_b},
                               {it.third_value, win_c}, 1'b1);
    end
    r.word_rep = claim_candidate(r.word_pat);
    win_a   = {it.first_value, win_a[WINDOW_W-1:8]};
    win_b   = {it.second_value, win_b[WINDOW_W-1:8]};
    win_c   = {it.third_value, win_c[WINDOW_W-1:8]};
    pos_cnt = (off != OFFSET_MAX) ? off + 1'b1 : off;
    r.count_ab = cnt_ab;
    r.count_bc = cnt_bc;
    return r;
  endfunction

  function automatic item_t make_item(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c, input logic reg_first,
                                      input logic cmp_first);
    item_t it;
    it.first_value      = a;
    it.second_value     = b;
    it.third_value      = c;
    it.region_first     = reg_first;
    it.comparison_first = cmp_first;
    return it;
  endfunction

  // send one transaction, with an occasional gap in front of it
  task automatic send_item(input item_t it);
    int gap;
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i         = 1'b1;
    first_value_i      = it.first_value;
    second_value_i     = it.second_value;
    third_value_i      = it.third_value;
    region_first_i     = it.region_first;
    comparison_first_i = it.comparison_first;
    do @(posedge clk_i); while (in_stall_o);
    classified_q.insert(classified_q.size(), classify_position(it));
  endtask

  // hold off the sender until every pending row has come out
  task automatic flush_pipeline();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (classified_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // register write, only issued while the core is idle
  task automatic set_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_wr_en_i = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = val;
    case (idx)
      CFG_CHANGE_LIMIT: lim_chg  = val[CHG_ROWS_W-1:0];
      CFG_CAND_LIMIT:   lim_cand = val[CAND_ROWS_W-1:0];
      CFG_RISE_LIMIT:   lim_rise = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_wr_en_i = 1'b0;
  endtask

  // four positions whose bytes form one little-endian word triple
  task automatic send_word();
    logic [31:0]     wa, wb, wc, rise;
    longint unsigned span;
    logic            reg_first;
    wa = $urandom;
    case ($urandom_range(0, 4))
      0: begin
        wa = '0;
        wb = 32'd1;
        wc = '0;
      end
      1: begin
        if ($urandom_range(0, 1)) wa[23:0] = '1;
        wb = wa + 32'd1;
        wc = wa;
      end
      default: begin
        case ($urandom_range(0, 2))
          0:       rise = $urandom_range(1, 2000);
          1:       rise = lim_rise;
          default: rise = lim_rise + 32'd1;
        endcase
        if (rise == 0) rise = 32'd1;
        span = 64'h1_0000_0000 - rise;
        wa   = 32'($urandom % span);
        wb   = wa + rise;
        wc   = $urandom % wb;
      end
    endcase
    reg_first = $urandom_range(0, 3) == 0;
    for (int i = 0; i < 4; i++) begin
      send_item(make_item(wa[8*i +: 8], wb[8*i +: 8], wc[8*i +: 8],
                          reg_first && i == 0, 1'b0));
    end
  endtask

  // mixed random positions, biased toward the pattern classes
  task automatic run_mixed_traffic(input int count, input int cmp_odds);
    int         sent;
    logic [7:0] a, b, c;
    logic       rf, cf;
    sent = 0;
    while (sent < count) begin
      a  = 8'($urandom);
      b  = 8'($urandom);
      c  = 8'($urandom);
      rf = $urandom_range(0, 39) == 0;
      cf = $urandom_range(0, cmp_odds - 1) == 0;
      case ($urandom_range(0, 9))
        3: begin
          a = 8'h00;
          b = 8'h01;
          c = 8'h00;
        end
        4: begin
          b = a + 8'd1;
          c = a;
        end
        5: begin
          b = 8'($urandom_range(1, 255));
          a = 8'($urandom_range(0, b - 1));
          c = 8'($urandom_range(0, b - 1));
        end
        6: begin
          b = a;
          c = a;
        end
        7, 8: begin
          send_word();
          sent += 4;
          continue;
        end
        default: ;
      endcase
      send_item(make_item(a, b, c, rf, cf));
      sent++;
    end
  endtask

  // byte classes and their edges
  task automatic test_byte_classes();
    send_item(make_item(8'h00, 8'h00, 8'h00, 1'b1, 1'b1));
    send_item(make_item(8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0));
    send_item(make_item(8'hFF, 8'h00, 8'hFF, 1'b0, 1'b0));
    send_item(make_item(8'h00, 8'h01, 8'h00, 1'b0, 1'b0));
    send_item(make_item(8'h05, 8'h06, 8'h05, 1'b0, 1'b0));
    send_item(make_item(8'h00, 8'hFF, 8'h00, 1'b0, 1'b0));
    send_item(make_item(8'h80, 8'h10, 8'h80, 1'b0, 1'b0));
    send_item(make_item(8'h7F, 8'h7F, 8'h80, 1'b0, 1'b0));
  endtask

  // word window: zero-one-zero, carried step, rise at and past the bound
  task automatic test_word_window();
    send_item(make_item(8'h00, 8'h01, 8'h00, 1'b1, 1'b0));
    repeat (3) send_item(make_item(8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
    send_item(make_item(8'hFF, 8'h00, 8'hFF, 1'b1, 1'b0));
    send_item(make_item(8'hFF, 8'h00, 8'hFF, 1'b0, 1'b0));
    send_item(make_item(8'hFF, 8'h00, 8'hFF, 1'b0, 1'b0));
    send_item(make_item(8'h12, 8'h13, 8'h12, 1'b0, 1'b0));
    send_item(make_item(8'h00, 8'hE8, 8'h00, 1'b1, 1'b0));
    send_item(make_item(8'h01, 8'h04, 8'h00, 1'b0, 1'b0));
    repeat (2) send_item(make_item(8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
    send_item(make_item(8'h00, 8'hE9, 8'h00, 1'b1, 1'b0));
    send_item(make_item(8'h01, 8'h04, 8'h00, 1'b0, 1'b0));
    repeat (2) send_item(make_item(8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
    // new comparison in the middle of a region keeps offset and window
    send_item(make_item(8'h33, 8'h34, 8'h33, 1'b0, 1'b1));
  endtask

  // row limits tiny, then every register at all ones
  task automatic test_row_limits();
    flush_pipeline();
    set_reg(CFG_CHANGE_LIMIT, 32'd2);
    set_reg(CFG_CAND_LIMIT, 32'd1);
    set_reg(CFG_RISE_LIMIT, 32'd0);
    send_item(make_item(8'h01, 8'h02, 8'h01, 1'b1, 1'b1));
    send_item(make_item(8'h00, 8'h01, 8'h00, 1'b0, 1'b0));
    send_item(make_item(8'h03, 8'h03, 8'h04, 1'b0, 1'b0));
    send_item(make_item(8'h10, 8'h20, 8'h10, 1'b0, 1'b0));
    send_item(make_item(8'h04, 8'h04, 8'h04, 1'b0, 1'b1));
    send_item(make_item(8'h00, 8'h01, 8'h00, 1'b0, 1'b0));
    flush_pipeline();
    set_reg(CFG_CHANGE_LIMIT, '1);
    set_reg(CFG_CAND_LIMIT, '1);
    set_reg(CFG_RISE_LIMIT, '1);
  endtask

  // random traffic under several register settings
  task automatic test_random_traffic();
    run_mixed_traffic(300, 150);
    flush_pipeline();
    set_reg(CFG_CHANGE_LIMIT, 32'(CHANGE_LIMIT_RST));
    set_reg(CFG_CAND_LIMIT, 32'(CAND_LIMIT_RST));
    set_reg(CFG_RISE_LIMIT, 32'(RISE_LIMIT_RST));
    run_mixed_traffic(450, 150);
    flush_pipeline();
    set_reg(CFG_CHANGE_LIMIT, '0);
    set_reg(CFG_CAND_LIMIT, '0);
    set_reg(CFG_RISE_LIMIT, '0);
    run_mixed_traffic(250, 100);
    flush_pipeline();
    set_reg(CFG_CHANGE_LIMIT, {13'($urandom_range(0, 8191)), 19'($urandom_range(0, 40))});
    set_reg(CFG_CAND_LIMIT, {15'($urandom_range(0, 32767)), 17'($urandom_range(0, 30))});
    set_reg(CFG_RISE_LIMIT, $urandom_range(0, 5000));
    run_mixed_traffic(500, 60);
  endtask

  // closing stretch with no idling on either side
  task automatic test_full_rate();
    flush_pipeline();
    calm = 1'b1;
    set_reg(CFG_CHANGE_LIMIT, $urandom_range(100, 300000));
    set_reg(CFG_CAND_LIMIT, $urandom_range(50, 100000));
    set_reg(CFG_RISE_LIMIT, $urandom);
    run_mixed_traffic(400, 120);
  endtask

  // main sequence
  initial begin
    rst_ni             = 1'b0;
    cfg_wr_en_i        = 1'b0;
    cfg_index_i        = CFG_CHANGE_LIMIT;
    cfg_wdata_i        = '0;
    in_valid_i         = 1'b0;
    first_value_i      = '0;
    second_value_i     = '0;
    third_value_i      = '0;
    region_first_i     = 1'b0;
    comparison_first_i = 1'b0;
    out_stall_i        = 1'b0;
    calm               = 1'b0;
    mismatch_cnt       = 0;
    lim_chg            = CHANGE_LIMIT_RST;
    lim_cand           = CAND_LIMIT_RST;
    lim_rise           = RISE_LIMIT_RST;
    pos_cnt            = '0;
    win_a              = '0;
    win_b              = '0;
    win_c              = '0;
    chg_rows           = '0;
    cand_rows          = '0;
    cnt_ab             = '0;
    cnt_bc             = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_byte_classes();
    test_word_window();
    test_row_limits();
    test_random_traffic();
    test_full_rate();

    flush_pipeline();
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("[three_snapshot_change_classifier_core] OK");
    end else begin
      $display("[three_snapshot_change_classifier_core] ERROR");
    end
    $finish;
  end

  // receiver stalls in random bursts, alternating with free runs
  initial begin
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (calm) begin
        out_stall_i = 1'b0;
        stall_left  = 0;
      end else if (stall_left == 0) begin
        out_stall_i = $urandom_range(0, 2) == 0;
        stall_left  = $urandom_range(1, 18);
      end
      if (stall_left > 0) stall_left--;
    end
  end

  // result check against the oldest pending row
  always @(posedge clk_i) begin
    result_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.offset     = offset_o;
      got.changed_ab = changed_first_second_o;
      got.changed_bc = changed_second_third_o;
      got.change_rep = change_reported_o;
      got.byte_pat   = pat_e'(byte_pattern_o);
      got.byte_rep   = byte_candidate_reported_o;
      got.word_pat   = pat_e'(word_pattern_o);
      got.word_rep   = word_candidate_reported_o;
      got.count_ab   = count_first_second_o;
      got.count_bc   = count_second_third_o;
      if (classified_q.size() == 0) begin
        if (mismatch_cnt < 10) $display("cycle %0d: result with none pending", cycle_cnt);
        mismatch_cnt++;
      end else begin
        want = classified_q.pop_front();
        if (got.offset !== want.offset || got.changed_ab !== want.changed_ab ||
            got.changed_bc !== want.changed_bc || got.change_rep !== want.change_rep ||
            got.byte_pat !== want.byte_pat || got.byte_rep !== want.byte_rep ||
            got.word_pat !== want.word_pat || got.word_rep !== want.word_rep ||
            got.count_ab !== want.count_ab || got.count_bc !== want.count_bc) begin
          if (mismatch_cnt < 10) begin
            $display("cycle %0d: mismatch (off ab bc chg bpat brep wpat wrep cnt_ab cnt_bc)",
                     cycle_cnt);
            $display("  want %0d %b %b %b %0d %b %0d %b %0d %0d", want.offset,
                     want.changed_ab, want.changed_bc, want.change_rep, want.byte_pat,
                     want.byte_rep, want.word_pat, want.word_rep, want.count_ab,
                     want.count_bc);
            $display("  got  %0d %b %b %b %0d %b %0d %b %0d %0d", got.offset,
                     got.changed_ab, got.changed_bc, got.change_rep, got.byte_pat,
                     got.byte_rep, got.word_pat, got.word_rep, got.count_ab,
                     got.count_bc);
          end
          mismatch_cnt++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[three_snapshot_change_classifier_core] ERROR");
      $finish;
    end
  end

  initial cycle_cnt = 0;

endmodule
